FILE: hw/rtl/lwbpp_pkg.sv
// ----------------------------------------------------------------------------
// LRU write-back page pool package
// Field widths, action codes, cell commands and shared types.
// ----------------------------------------------------------------------------
package lwbpp_pkg;

    localparam int POOL_ENTRIES_DEF = 16;
    localparam int PAGE_ID_BITS_DEF = 16;

    localparam int ACTION_W  = 3;
    localparam int PAGE_IN_W = 16;
    localparam int SLOT_W    = 4;
    localparam int LIMIT_W   = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ      = 3'd0,
        ACT_WRITE     = 3'd1,
        ACT_FLUSH     = 3'd2,
        ACT_FLUSH_ALL = 3'd3,
        ACT_SHUTDOWN  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PROMOTE,
        OP_FILL,
        OP_SET_DIRTY,
        OP_CLR_DIRTY,
        OP_CLEAR_ALL
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sel;
    } t_cell_cmd;

    typedef struct packed {
        logic valid;
        logic dirty;
        logic match;
    } t_cell_stat;

    typedef struct packed {
        logic                 status;
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 wb_valid;
        logic [PAGE_IN_W-1:0] wb_page;
        logic [SLOT_W-1:0]    wb_slot;
        logic                 last;
    } t_rsp;

    localparam t_rsp RSP_DONE = '{last: 1'b1, default: '0};

endpackage

FILE: hw/rtl/lwbpp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one pool request.
// ----------------------------------------------------------------------------
interface lwbpp_req_if import lwbpp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [PAGE_IN_W-1:0] page_id;

    modport source (output valid, output action, output page_id, input ready);
    modport sink   (input valid, input action, input page_id, output ready);
endinterface

FILE: hw/rtl/lwbpp_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result of a pool request.
// ----------------------------------------------------------------------------
interface lwbpp_rsp_if import lwbpp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 writeback_valid;
    logic [PAGE_IN_W-1:0] writeback_page;
    logic [SLOT_W-1:0]    writeback_slot;
    logic                 last;

    modport source (
        output valid, output status, output hit, output slot, output writeback_valid,
        output writeback_page, output writeback_slot, output last, input ready
    );
    modport sink (
        input valid, input status, input hit, input slot, input writeback_valid,
        input writeback_page, input writeback_slot, input last, output ready
    );
endinterface

FILE: hw/rtl/lwbpp_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the pool limit register.
// ----------------------------------------------------------------------------
interface lwbpp_cfg_if import lwbpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lwbpp_cell.sv
// ----------------------------------------------------------------------------
// Pool directory cell
// One directory entry with its recency rank, plus one stage of the
// minimum-page sweep chain used by flush all and shutdown.
// ----------------------------------------------------------------------------
module lwbpp_cell import lwbpp_pkg::*; #(
    parameter int PW  = PAGE_ID_BITS_DEF,
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic [IW-1:0] i_rank,
    input  logic [PW-1:0] i_page,
    input  logic [PW-1:0] i_lk_page,
    output t_cell_stat    o_stat,
    output logic [IW-1:0] o_rank,
    output logic [PW-1:0] o_page,
    input  logic          i_sw_found,
    input  logic [PW-1:0] i_sw_page,
    input  logic [IW-1:0] i_sw_idx,
    output logic          o_sw_found,
    output logic [PW-1:0] o_sw_page,
    output logic [IW-1:0] o_sw_idx
);

    logic          r_valid, n_valid;
    logic          r_dirty, n_dirty;
    logic [IW-1:0] r_rank, n_rank;
    logic [PW-1:0] r_page, n_page;
    logic          r_sw_found;
    logic [PW-1:0] r_sw_page;
    logic [IW-1:0] r_sw_idx;
    logic          take_own;

    always_comb begin
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_rank  = r_rank;
        n_page  = r_page;
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_PROMOTE: begin
                if (i_cmd.sel) begin
                    n_rank = '0;
                end else if (r_valid && (r_rank < i_rank)) begin
                    n_rank = r_rank + IW'(1);
                end
            end
            OP_FILL: begin
                if (i_cmd.sel) begin
                    n_valid = 1'b1;
                    n_dirty = 1'b0;
                    n_rank  = '0;
                    n_page  = i_page;
                end else if (r_valid) begin
                    n_rank = r_rank + IW'(1);
                end
            end
            OP_SET_DIRTY: begin
                if (i_cmd.sel) begin
                    n_dirty = 1'b1;
                end
            end
            OP_CLR_DIRTY: begin
                if (i_cmd.sel) begin
                    n_dirty = 1'b0;
                end
            end
            OP_CLEAR_ALL: begin
                n_valid = 1'b0;
                n_dirty = 1'b0;
                n_rank  = '0;
            end
            default: begin
            end
        endcase
    end

    // pass on the smaller dirty page
    assign take_own = r_valid && r_dirty && (!i_sw_found || (r_page < i_sw_page));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_rank  <= n_rank;
        end
        r_page     <= n_page;
        r_sw_found <= take_own || i_sw_found;
        r_sw_page  <= take_own ? r_page : i_sw_page;
        r_sw_idx   <= take_own ? IW'(IDX) : i_sw_idx;
    end

    assign o_stat.valid = r_valid;
    assign o_stat.dirty = r_dirty;
    assign o_stat.match = r_valid && (r_page == i_lk_page);
    assign o_rank       = r_rank;
    assign o_page       = r_page;
    assign o_sw_found   = r_sw_found;
    assign o_sw_page    = r_sw_page;
    assign o_sw_idx     = r_sw_idx;

endmodule

FILE: hw/rtl/lru_write_back_page_pool_top.sv
// ----------------------------------------------------------------------------
// LRU write-back page pool
// Directory of a fully associative page pool: LRU replacement, dirty marks,
// single-page flush, flush all and shutdown write-back sweeps.
//
//   channel  dir  handshake            payload
//   i_req    in   valid/ready          action, page_id
//   o_rsp    out  valid/ready          status, hit, slot, writeback_*, last
//   i_cfg    in   valid/ready (always) pool_limit
//
// Read, write and flush pass through the request register, then an
// associative update across the cell row once the result register is free.
// Flush all and shutdown run the sweep once along the cell chain per dirty
// page, plus a last pass that finds no dirty page.
// Reset clears valid, dirty and rank bits at once; no clearing pass.
// The result register holds under a stall; a sweep holds at the chain end.
// ----------------------------------------------------------------------------
module lru_write_back_page_pool_top import lwbpp_pkg::*; #(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lwbpp_req_if.sink   i_req,
    lwbpp_cfg_if.sink   i_cfg,
    lwbpp_rsp_if.source o_rsp
);

    localparam int N  = POOL_ENTRIES;
    localparam int PW = PAGE_ID_BITS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SWEEP} t_state;

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [PW-1:0]       r_page, n_page;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_old_rank, n_old_rank;
    logic                r_dirty, n_dirty;
    logic                r_pend_valid, n_pend_valid;
    logic [PW-1:0]       r_pend_page, n_pend_page;
    logic [IW-1:0]       r_pend_slot, n_pend_slot;

    t_cell_cmd     cmd [N];
    t_cell_stat    stat [N];
    logic [IW-1:0] rank [N];
    logic [PW-1:0] page [N];
    logic          sw_found [N+1];
    logic [PW-1:0] sw_page [N+1];
    logic [IW-1:0] sw_idx [N+1];

    t_cell_op      cmd_op;
    logic [IW-1:0] cmd_slot;
    logic [IW-1:0] bus_rank;
    logic [PW-1:0] lk_page;

    logic          hit_any;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] hit_rank;
    logic          hit_dirty;
    logic [IW-1:0] v_idx;
    logic [PW-1:0] v_page;
    logic          v_dirty;
    logic [IW-1:0] f_idx;
    logic [CW-1:0] lim;
    logic          evict;
    logic          out_free;
    t_rsp          res;

    assign lk_page = PW'(i_req.page_id);

    assign sw_found[0] = 1'b0;
    assign sw_page[0]  = '0;
    assign sw_idx[0]   = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        assign cmd[k] = '{op: cmd_op, sel: (cmd_slot == IW'(k))};

        lwbpp_cell #(
            .PW  (PW),
            .IW  (IW),
            .IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd[k]),
            .i_rank     (bus_rank),
            .i_page     (r_page),
            .i_lk_page  (lk_page),
            .o_stat     (stat[k]),
            .o_rank     (rank[k]),
            .o_page     (page[k]),
            .i_sw_found (sw_found[k]),
            .i_sw_page  (sw_page[k]),
            .i_sw_idx   (sw_idx[k]),
            .o_sw_found (sw_found[k+1]),
            .o_sw_page  (sw_page[k+1]),
            .o_sw_idx   (sw_idx[k+1])
        );
    end

    always_comb begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        hit_rank  = '0;
        hit_dirty = 1'b0;
        v_idx     = '0;
        v_page    = '0;
        v_dirty   = 1'b0;
        f_idx     = '0;
        for (int k = 0; k < N; k++) begin
            if (stat[k].match) begin
                hit_any   = 1'b1;
                hit_idx   = hit_idx | IW'(k);
                hit_rank  = hit_rank | rank[k];
                hit_dirty = hit_dirty | stat[k].dirty;
            end
            if (stat[k].valid && (rank[k] == IW'(r_count - CW'(1)))) begin
                v_idx   = v_idx | IW'(k);
                v_page  = v_page | page[k];
                v_dirty = v_dirty | stat[k].dirty;
            end
        end
        for (int k = N - 1; k >= 0; k--) begin
            if (!stat[k].valid) begin
                f_idx = IW'(k);
            end
        end
    end

    always_comb begin
        if (r_limit == '0) begin
            lim = CW'(1);
        end else if (int'(r_limit) > N) begin
            lim = CW'(N);
        end else begin
            lim = CW'(r_limit);
        end
    end

    assign evict    = (r_count >= lim);
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        n_limit      = i_cfg.valid ? i_cfg.data : r_limit;
        n_count      = r_count;
        n_cnt        = r_cnt;
        n_act        = r_act;
        n_page       = r_page;
        n_hit        = r_hit;
        n_idx        = r_idx;
        n_old_rank   = r_old_rank;
        n_dirty      = r_dirty;
        n_pend_valid = r_pend_valid;
        n_pend_page  = r_pend_page;
        n_pend_slot  = r_pend_slot;
        cmd_op       = OP_NONE;
        cmd_slot     = r_idx;
        bus_rank     = r_old_rank;
        res          = RSP_DONE;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_act      = i_req.action;
                    n_page     = lk_page;
                    n_hit      = hit_any;
                    n_idx      = hit_idx;
                    n_old_rank = hit_rank;
                    n_dirty    = hit_dirty;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if ((r_act == ACT_FLUSH_ALL) || (r_act == ACT_SHUTDOWN)) begin
                    n_cnt        = '0;
                    n_pend_valid = 1'b0;
                    n_state      = ST_SWEEP;
                end else if (out_free) begin
                    unique case (r_act)
                        ACT_READ: begin
                            if (r_hit) begin
                                res.hit = 1'b1;
                                res.slot = SLOT_W'(r_idx);
                                cmd_op = OP_PROMOTE;
                            end else begin
                                cmd_op   = OP_FILL;
                                cmd_slot = evict ? v_idx : f_idx;
                                res.slot = SLOT_W'(cmd_slot);
                                if (evict && v_dirty) begin
                                    res.wb_valid = 1'b1;
                                    res.wb_page  = PAGE_IN_W'(v_page);
                                    res.wb_slot  = SLOT_W'(v_idx);
                                end
                                if (!evict) begin
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        ACT_WRITE: begin
                            if (r_hit) begin
                                cmd_op = OP_SET_DIRTY;
                            end else begin
                                res.status = 1'b1;
                            end
                        end
                        ACT_FLUSH: begin
                            if (!r_hit) begin
                                res.status = 1'b1;
                            end else if (r_dirty) begin
                                cmd_op       = OP_CLR_DIRTY;
                                res.wb_valid = 1'b1;
                                res.wb_page  = PAGE_IN_W'(r_page);
                                res.wb_slot  = SLOT_W'(r_idx);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_out       = res;
                    n_state     = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (r_cnt != CW'(N)) begin
                    n_cnt = r_cnt + CW'(1);
                end else if (sw_found[N]) begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            res.wb_valid = 1'b1;
                            res.wb_page  = PAGE_IN_W'(r_pend_page);
                            res.wb_slot  = SLOT_W'(r_pend_slot);
                            res.last     = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out        = res;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_page  = sw_page[N];
                        n_pend_slot  = sw_idx[N];
                        cmd_op       = OP_CLR_DIRTY;
                        cmd_slot     = sw_idx[N];
                        n_cnt        = '0;
                    end
                end else if (out_free) begin
                    if (r_pend_valid) begin
                        res.wb_valid = 1'b1;
                        res.wb_page  = PAGE_IN_W'(r_pend_page);
                        res.wb_slot  = SLOT_W'(r_pend_slot);
                    end
                    n_out_valid  = 1'b1;
                    n_out        = res;
                    n_pend_valid = 1'b0;
                    if (r_act == ACT_SHUTDOWN) begin
                        cmd_op  = OP_CLEAR_ALL;
                        n_count = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_limit      <= LIMIT_RESET;
            r_count      <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_limit      <= n_limit;
            r_count      <= n_count;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
        end
        r_out       <= n_out;
        r_act       <= n_act;
        r_page      <= n_page;
        r_hit       <= n_hit;
        r_idx       <= n_idx;
        r_old_rank  <= n_old_rank;
        r_dirty     <= n_dirty;
        r_pend_page <= n_pend_page;
        r_pend_slot <= n_pend_slot;
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.hit             = r_out.hit;
    assign o_rsp.slot            = r_out.slot;
    assign o_rsp.writeback_valid = r_out.wb_valid;
    assign o_rsp.writeback_page  = r_out.wb_page;
    assign o_rsp.writeback_slot  = r_out.wb_slot;
    assign o_rsp.last            = r_out.last;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back page pool testbench
// Sends reads, writes, flushes, sweeps and reserved actions under several pool
// limits, with random idling on both channels and one long result hold-off.
// A directory model of the pool gives the expected results; every result is
// checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lwbpp_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT    = 23;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOT_PAGES   = 20;

    localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_C = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lwbpp_req_if req_ch ();
    lwbpp_cfg_if cfg_ch ();
    lwbpp_rsp_if rsp_ch ();

    lru_write_back_page_pool_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // directory model
    logic                 pool_valid [POOL_ENTRIES_DEF] = '{default: 1'b0};
    logic [PAGE_IN_W-1:0] pool_page  [POOL_ENTRIES_DEF] = '{default: '0};
    logic                 pool_dirty [POOL_ENTRIES_DEF] = '{default: 1'b0};
    int                   pool_rank  [POOL_ENTRIES_DEF] = '{default: 0};
    logic [LIMIT_W-1:0]   pool_limit_reg = LIMIT_RESET;

    t_rsp pending_results [$];

    int error_count   = 0;
    int quiet_cycles  = 0;
    int stall_request = 0;
    bit steady        = 1'b0;
    bit req_offered   = 1'b0;
    bit cfg_offered   = 1'b0;

    function automatic t_rsp rsp_of(input logic st, input logic hit, input int slot,
                                    input logic wv, input logic [PAGE_IN_W-1:0] wp,
                                    input int ws, input logic last);
        t_rsp r;
        r.status   = st;
        r.hit      = hit;
        r.slot     = SLOT_W'(slot);
        r.wb_valid = wv;
        r.wb_page  = wp;
        r.wb_slot  = SLOT_W'(ws);
        r.last     = last;
        return r;
    endfunction

    function automatic int find_page(input logic [PAGE_IN_W-1:0] page);
        for (int i = 0; i < POOL_ENTRIES_DEF; i++)
            if (pool_valid[i] && pool_page[i] == page)
                return i;
        return -1;
    endfunction

    // one write-back per dirty page, ascending page number
    function automatic void predict_write_back_all();
        int best;
        int n;
        n = 0;
        do begin
            best = -1;
            for (int i = 0; i < POOL_ENTRIES_DEF; i++)
                if (pool_valid[i] && pool_dirty[i] &&
                    (best < 0 || pool_page[i] < pool_page[best]))
                    best = i;
            if (best >= 0) begin
                pool_dirty[best] = 1'b0;
                pending_results.push_back(rsp_of(1'b0, 1'b0, 0, 1'b1, pool_page[best],
                                                 best, 1'b0));
                n++;
            end
        end while (best >= 0);
        if (n == 0)
            pending_results.push_back(RSP_DONE);
        else
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void predict_pool_results(input logic [ACTION_W-1:0] act,
                                                 input logic [PAGE_IN_W-1:0] page);
        int s;
        int occupied;
        int lim;
        int old_rank;
        logic wv;
        logic [PAGE_IN_W-1:0] wp;
        int ws;
        s = find_page(page);
        case (act)
            ACT_READ: begin
                if (s >= 0) begin
                    old_rank = pool_rank[s];
                    for (int i = 0; i < POOL_ENTRIES_DEF; i++)
                        if (pool_valid[i] && pool_rank[i] < old_rank)
                            pool_rank[i]++;
                    pool_rank[s] = 0;
                    pending_results.push_back(rsp_of(1'b0, 1'b1, s, 1'b0, '0, 0, 1'b1));
                end else begin
                    wv = 1'b0;
                    wp = '0;
                    ws = 0;
                    occupied = 0;
                    for (int i = 0; i < POOL_ENTRIES_DEF; i++)
                        if (pool_valid[i]) occupied++;
                    lim = (pool_limit_reg == 0) ? 1 :
                          (pool_limit_reg > POOL_ENTRIES_DEF) ? POOL_ENTRIES_DEF :
                          int'(pool_limit_reg);
                    if (occupied >= lim) begin
                        for (int i = 0; i < POOL_ENTRIES_DEF; i++)
                            if (pool_valid[i] && (s < 0 || pool_rank[i] > pool_rank[s]))
                                s = i;
                        if (s < 0) s = 0;
                        if (pool_valid[s] && pool_dirty[s]) begin
                            wv = 1'b1;
                            wp = pool_page[s];
                            ws = s;
                        end
                        pool_valid[s] = 1'b0;
                        pool_dirty[s] = 1'b0;
                    end else begin
                        for (int i = POOL_ENTRIES_DEF - 1; i >= 0; i--)
                            if (!pool_valid[i]) s = i;
                        if (s < 0) s = 0;
                    end
                    for (int i = 0; i < POOL_ENTRIES_DEF; i++)
                        if (pool_valid[i]) pool_rank[i]++;
                    pool_valid[s] = 1'b1;
                    pool_page[s]  = page;
                    pool_dirty[s] = 1'b0;
                    pool_rank[s]  = 0;
                    pending_results.push_back(rsp_of(1'b0, 1'b0, s, wv, wp, ws, 1'b1));
                end
            end
            ACT_WRITE: begin
                if (s < 0) begin
                    pending_results.push_back(rsp_of(1'b1, 1'b0, 0, 1'b0, '0, 0, 1'b1));
                end else begin
                    pool_dirty[s] = 1'b1;
                    pending_results.push_back(RSP_DONE);
                end
            end
            ACT_FLUSH: begin
                if (s < 0) begin
                    pending_results.push_back(rsp_of(1'b1, 1'b0, 0, 1'b0, '0, 0, 1'b1));
                end else if (pool_dirty[s]) begin
                    pool_dirty[s] = 1'b0;
                    pending_results.push_back(rsp_of(1'b0, 1'b0, 0, 1'b1, pool_page[s],
                                                     s, 1'b1));
                end else begin
                    pending_results.push_back(RSP_DONE);
                end
            end
            ACT_FLUSH_ALL: predict_write_back_all();
            ACT_SHUTDOWN: begin
                predict_write_back_all();
                pool_valid = '{default: 1'b0};
                pool_dirty = '{default: 1'b0};
                pool_rank  = '{default: 0};
            end
            default: pending_results.push_back(RSP_DONE);
        endcase
    endfunction

    task automatic send_req(input logic [ACTION_W-1:0] act,
                            input logic [PAGE_IN_W-1:0] page);
        if (cfg_offered) begin
            cfg_ch.valid <= 1'b0;
            cfg_offered = 1'b0;
        end
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            if (req_offered) begin
                req_ch.valid <= 1'b0;
                req_offered = 1'b0;
            end
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.page_id <= page;
        req_offered = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_pool_results(act, page);
    endtask

    task automatic drain_results();
        if (req_offered) begin
            req_ch.valid <= 1'b0;
            req_offered = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_pool_limit(input logic [LIMIT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        cfg_offered = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        pool_limit_reg = value;
    endtask

    task automatic test_directed_ops();
        send_req(ACT_READ, 16'h0000);
        send_req(ACT_READ, 16'hFFFF);
        send_req(ACT_READ, 16'hAAAA);
        send_req(ACT_READ, 16'h5555);
        send_req(ACT_READ, 16'hFFFF);
        send_req(ACT_WRITE, 16'hFFFF);
        send_req(ACT_WRITE, 16'h1234);
        send_req(ACT_FLUSH, 16'h1234);
        send_req(ACT_FLUSH, 16'hAAAA);
        send_req(ACT_FLUSH, 16'hFFFF);
        send_req(ACT_WRITE, 16'h5555);
        send_req(ACT_WRITE, 16'h0000);
        send_req(ACT_FLUSH_ALL, 16'hFFFF);
        send_req(ACT_FLUSH_ALL, 16'h0000);
        send_req(ACT_RSVD_A, 16'hFFFF);
        send_req(ACT_RSVD_B, 16'h8001);
        send_req(ACT_RSVD_C, 16'h0000);
        send_req(ACT_WRITE, 16'hAAAA);
        send_req(ACT_SHUTDOWN, 16'h1234);
        send_req(ACT_SHUTDOWN, 16'h0000);
        drain_results();
    endtask

    task automatic test_limit_extremes();
        write_pool_limit(5'd1);
        send_req(ACT_READ, 16'h0F0F);
        send_req(ACT_WRITE, 16'h0F0F);
        send_req(ACT_READ, 16'hF0F0);
        send_req(ACT_READ, 16'hF0F0);
        drain_results();
        write_pool_limit(5'd0);
        send_req(ACT_READ, 16'h8001);
        drain_results();
        write_pool_limit(5'd31);
        send_req(ACT_READ, 16'h0001);
        send_req(ACT_READ, 16'h0002);
        drain_results();
        // shrink the limit below occupancy
        write_pool_limit(5'd2);
        send_req(ACT_READ, 16'h0003);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_pool_limit(5'd16);
        stall_request = HOLD_CYCLES;
        steady = 1'b1;
        repeat (12)
            send_req($urandom_range(1) ? ACT_READ : ACT_WRITE, 16'($urandom_range(15)));
        drain_results();
        steady = 1'b0;
    endtask

    task automatic run_random_phase(input logic [LIMIT_W-1:0] limit, input int items,
                                    input bit no_idle);
        logic [PAGE_IN_W-1:0] hot [HOT_PAGES];
        logic [PAGE_IN_W-1:0] page;
        logic [ACTION_W-1:0]  act;
        int roll;
        write_pool_limit(limit);
        steady = no_idle;
        foreach (hot[k])
            hot[k] = 16'($urandom_range(16'hFFFF));
        repeat (items) begin
            roll = $urandom_range(99);
            if ($urandom_range(99) < 85)
                page = hot[$urandom_range(HOT_PAGES - 1)];
            else
                page = 16'($urandom_range(16'hFFFF));
            if (roll < 50)      act = ACT_READ;
            else if (roll < 72) act = ACT_WRITE;
            else if (roll < 84) act = ACT_FLUSH;
            else if (roll < 89) act = ACT_FLUSH_ALL;
            else if (roll < 93) act = ACT_SHUTDOWN;
            else                act = ACTION_W'($urandom_range(ACT_RSVD_C, ACT_RSVD_A));
            send_req(act, page);
        end
        drain_results();
        steady = 1'b0;
    endtask

    task automatic test_random();
        run_random_phase(5'd16, 30, 1'b0);
        run_random_phase(5'd4, 30, 1'b0);
        run_random_phase(5'd1, 25, 1'b0);
        run_random_phase(5'd31, 30, 1'b1);
        run_random_phase(5'd0, 20, 1'b0);
        run_random_phase(LIMIT_W'($urandom_range(15, 2)), 30, 1'b0);
        run_random_phase(LIMIT_W'($urandom_range(31)), 30, 1'b0);
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(rsp_ch.status));
                check_field("hit", 16'(want.hit), 16'(rsp_ch.hit));
                check_field("slot", 16'(want.slot), 16'(rsp_ch.slot));
                check_field("writeback_valid", 16'(want.wb_valid),
                            16'(rsp_ch.writeback_valid));
                check_field("writeback_page", want.wb_page, rsp_ch.writeback_page);
                check_field("writeback_slot", 16'(want.wb_slot),
                            16'(rsp_ch.writeback_slot));
                check_field("last", 16'(want.last), 16'(rsp_ch.last));
            end
        end
    end

    initial begin : rsp_sink
        int hold;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main_seq
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.action  <= '0;
        req_ch.page_id <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_limit_extremes();
        test_backpressure();
        test_random();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
